// File: rtl/core/hsow_pkg.sv
// Shared types and constants for the hyperslab offset walker.
package hsow_pkg;

	localparam int MAX_DIMS_DEF = 4;
	localparam int DIM_BITS_DEF = 16;

	localparam int CFG_W   = 64;
	localparam int ADDR_W  = 5;
	localparam int DIMS_W  = 3;
	localparam int OFF_W   = 64;
	localparam int STAT_W  = 2;

	// register indexes, byte address is 8 * index
	localparam logic [1:0] REG_DIMS   = 2'd0;
	localparam logic [1:0] REG_SIZES  = 2'd1;
	localparam logic [1:0] REG_STARTS = 2'd2;
	localparam logic [1:0] REG_COUNTS = 2'd3;

	localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_INVALID = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_EMPTY   = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACCUM,
		ST_FINISH
	} state_t;

endpackage

// File: rtl/core/hyperslab_offset_walker_top.sv
// Hyperslab offset walker: sequencer, shared multiply-add unit and config registers.
//
// Usage:
//   Program dims_in_use, dim_sizes, dim_starts and dim_counts through the APB port
//   (byte addresses 0x00, 0x08, 0x10, 0x18, 64-bit data) while the block is idle.
//   Each beat on the input channel (in_valid/in_stall, field restart) yields one beat
//   on the output channel: source_offset, slab_offset, last_element, walk_status.
//   restart=1 returns the walk to the origin before the element is produced.
// Timing:
//   One shared multiply-add unit folds one dimension per cycle into both offsets,
//   so the sequencer stays in ACCUM for each dimension in use (at most MAX_DIMS),
//   then passes through FINISH before the next item is accepted. With an invalid or
//   empty slab or no dimensions the fold is skipped and the item goes to FINISH.
//   in_stall stays high from accept until the result is loaded.
// Reset:
//   arst_n clears the registers, the indices and the output valid at once.
// Stall:
//   A stalled result holds in the output register; a finished item waits in the
//   sequencer until the output register frees, and no new item is taken meanwhile.
module hyperslab_offset_walker_top #(
	parameter int MAX_DIMS = hsow_pkg::MAX_DIMS_DEF,
	parameter int DIM_BITS = hsow_pkg::DIM_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// APB configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [hsow_pkg::ADDR_W-1:0]   paddr,
	input  logic [hsow_pkg::CFG_W-1:0]    pwdata,
	output logic [hsow_pkg::CFG_W-1:0]    prdata,
	output logic                          pready,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          restart,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [hsow_pkg::OFF_W-1:0]    source_offset,
	output logic [hsow_pkg::OFF_W-1:0]    slab_offset,
	output logic                          last_element,
	output logic [hsow_pkg::STAT_W-1:0]   walk_status
);

	localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

	// config registers
	logic [hsow_pkg::DIMS_W-1:0] dims_q;
	logic [hsow_pkg::CFG_W-1:0]  sizes_q;
	logic [hsow_pkg::CFG_W-1:0]  starts_q;
	logic [hsow_pkg::CFG_W-1:0]  counts_q;

	// walk state and sequencer
	logic [DIM_BITS-1:0]         idx_q [MAX_DIMS];
	logic [DIM_BITS-1:0]         idx_next [MAX_DIMS];
	hsow_pkg::state_t            state_q, state_d;
	logic [DW-1:0]               d_q;
	logic [hsow_pkg::OFF_W-1:0]  src_q, dst_q;
	logic                        last_q;
	logic [hsow_pkg::STAT_W-1:0] status_q;

	// output register
	logic                        out_valid_q;
	logic [hsow_pkg::OFF_W-1:0]  src_out_q, dst_out_q;
	logic                        last_out_q;
	logic [hsow_pkg::STAT_W-1:0] status_out_q;

	logic [DIM_BITS-1:0]         sz_f [MAX_DIMS];
	logic [DIM_BITS-1:0]         st_f [MAX_DIMS];
	logic [DIM_BITS-1:0]         ct_f [MAX_DIMS];
	logic [hsow_pkg::DIMS_W-1:0] n_w;
	logic                        invalid_w, empty_w;
	logic                        in_acc, out_acc, out_free, load_out, step_last;
	logic                        cfg_wr;
	logic [hsow_pkg::OFF_W-1:0]  src_mac, dst_mac;
	logic [DIM_BITS-1:0]         ix_sel, sz_sel, st_sel, ct_sel;

	// unpack per-dimension fields
	for (genvar g = 0; g < MAX_DIMS; g++) begin : g_field
		assign sz_f[g] = sizes_q[g*DIM_BITS +: DIM_BITS];
		assign st_f[g] = starts_q[g*DIM_BITS +: DIM_BITS];
		assign ct_f[g] = counts_q[g*DIM_BITS +: DIM_BITS];
	end

	assign n_w = (dims_q > hsow_pkg::DIMS_W'(MAX_DIMS)) ? hsow_pkg::DIMS_W'(MAX_DIMS) : dims_q;

	// slab checks over the dimensions in use
	always_comb begin
		invalid_w = 1'b0;
		empty_w   = 1'b0;
		for (int i = 0; i < MAX_DIMS; i++) begin
			if (i < int'(n_w)) begin
				if (({1'b0, st_f[i]} + {1'b0, ct_f[i]}) > {1'b0, sz_f[i]})
					invalid_w = 1'b1;
				if (ct_f[i] == '0)
					empty_w = 1'b1;
			end
		end
	end

	// APB
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q   <= '0;
			sizes_q  <= '0;
			starts_q <= '0;
			counts_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[4:3])
				hsow_pkg::REG_DIMS:   dims_q   <= pwdata[hsow_pkg::DIMS_W-1:0];
				hsow_pkg::REG_SIZES:  sizes_q  <= pwdata;
				hsow_pkg::REG_STARTS: starts_q <= pwdata;
				hsow_pkg::REG_COUNTS: counts_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			hsow_pkg::REG_DIMS:   prdata = {{(hsow_pkg::CFG_W-hsow_pkg::DIMS_W){1'b0}}, dims_q};
			hsow_pkg::REG_SIZES:  prdata = sizes_q;
			hsow_pkg::REG_STARTS: prdata = starts_q;
			hsow_pkg::REG_COUNTS: prdata = counts_q;
			default:              prdata = '0;
		endcase
	end

	// handshakes
	assign in_stall = (state_q != hsow_pkg::ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_acc  = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || !out_stall;

	// shared multiply-add unit: one dimension per cycle, both offsets
	assign ix_sel  = idx_q[d_q];
	assign sz_sel  = sz_f[d_q];
	assign st_sel  = st_f[d_q];
	assign ct_sel  = ct_f[d_q];
	assign src_mac = src_q * hsow_pkg::OFF_W'(sz_sel) + hsow_pkg::OFF_W'(ix_sel)
		+ hsow_pkg::OFF_W'(st_sel);
	assign dst_mac = dst_q * hsow_pkg::OFF_W'(ct_sel) + hsow_pkg::OFF_W'(ix_sel);

	assign step_last = (hsow_pkg::DIMS_W'(d_q) + hsow_pkg::DIMS_W'(1)) == n_w;

	// odometer advance, last dimension in use fastest
	always_comb begin
		logic carry;
		logic [DIM_BITS:0] inc;
		carry = 1'b1;
		inc   = '0;
		for (int i = MAX_DIMS - 1; i >= 0; i--) begin
			idx_next[i] = idx_q[i];
			if (i < int'(n_w) && carry) begin
				inc = {1'b0, idx_q[i]} + {{DIM_BITS{1'b0}}, 1'b1};
				if (inc >= {1'b0, ct_f[i]}) begin
					idx_next[i] = '0;
				end else begin
					idx_next[i] = inc[DIM_BITS-1:0];
					carry       = 1'b0;
				end
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= hsow_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	assign load_out = (state_q == hsow_pkg::ST_FINISH) && out_free;

	always_comb begin
		state_d = state_q;
		case (state_q)
			hsow_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (invalid_w || empty_w || n_w == '0)
						state_d = hsow_pkg::ST_FINISH;
					else
						state_d = hsow_pkg::ST_ACCUM;
				end
			end
			hsow_pkg::ST_ACCUM: begin
				if (step_last)
					state_d = hsow_pkg::ST_FINISH;
			end
			hsow_pkg::ST_FINISH: begin
				if (out_free)
					state_d = hsow_pkg::ST_IDLE;
			end
			default: state_d = hsow_pkg::ST_IDLE;
		endcase
	end

	// indices
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_DIMS; i++)
				idx_q[i] <= '0;
		end else if (in_acc && restart) begin
			for (int i = 0; i < MAX_DIMS; i++)
				idx_q[i] <= '0;
		end else if (state_q == hsow_pkg::ST_ACCUM && step_last) begin
			for (int i = 0; i < MAX_DIMS; i++)
				idx_q[i] <= idx_next[i];
		end
	end

	// accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_q <= '0;
		end else if (in_acc) begin
			d_q <= '0;
		end else if (state_q == hsow_pkg::ST_ACCUM && !step_last) begin
			d_q <= d_q + DW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			src_q  <= '0;
			dst_q  <= '0;
			last_q <= 1'b1;
			if (invalid_w)
				status_q <= hsow_pkg::STATUS_INVALID;
			else if (empty_w)
				status_q <= hsow_pkg::STATUS_EMPTY;
			else
				status_q <= hsow_pkg::STATUS_OK;
		end else if (state_q == hsow_pkg::ST_ACCUM) begin
			src_q  <= src_mac;
			dst_q  <= dst_mac;
			last_q <= last_q && (ix_sel == ct_sel - DIM_BITS'(1));
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (out_acc)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			src_out_q    <= src_q;
			dst_out_q    <= dst_q;
			last_out_q   <= last_q;
			status_out_q <= status_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign source_offset = src_out_q;
	assign slab_offset   = dst_out_q;
	assign last_element  = last_out_q;
	assign walk_status   = status_out_q;

endmodule

// File: rtl/core/hsow_checker.sv
// Port-level checker for the hyperslab offset walker, bound to the top level.
module hsow_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [hsow_pkg::OFF_W-1:0]  source_offset,
	input logic [hsow_pkg::OFF_W-1:0]  slab_offset,
	input logic                        last_element,
	input logic [hsow_pkg::STAT_W-1:0] walk_status
);

	// busy right after an accepted beat
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while an item is in progress");

	// a result never appears on the edge right after an accept
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result appeared too early");

	// an error status carries zero offsets and the last mark
	a_error_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && walk_status != hsow_pkg::STATUS_OK |->
		source_offset == '0 && slab_offset == '0 && last_element)
		else $error("error result with nonzero offsets or without last mark");

	// a stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(source_offset)
		&& $stable(slab_offset) && $stable(last_element) && $stable(walk_status))
		else $error("stalled result changed");

endmodule

bind hyperslab_offset_walker_top hsow_checker u_hsow_checker (.*);
